// ----- rtl/nfass_pkg.sv -----
// ----------------------------------------------------------------------------
// nfass_pkg
// Shared types and constants of the NFA state set engine.
// ----------------------------------------------------------------------------
package nfass_pkg;

    // Operation codes carried in the input item's tuser.
    localparam logic [2:0] OP_WRITE_EDGE = 3'd0;
    localparam logic [2:0] OP_WRITE_WORD = 3'd1;
    localparam logic [2:0] OP_CLOSURE    = 3'd2;
    localparam logic [2:0] OP_MOVE       = 3'd3;
    localparam logic [2:0] OP_READ       = 3'd4;

    // Field widths fixed by the item format.
    localparam int STATE_W  = 8;
    localparam int LABEL_W  = 9;
    localparam int EIDX_W   = 10;
    localparam int WIDX_W   = 2;
    localparam int WORD_W   = 64;
    localparam int CFG_W    = 11;
    localparam int EDGE_W   = STATE_W + LABEL_W + STATE_W;
    localparam int IN_DATA_W = 104;

    // The label pattern that marks an epsilon edge.
    localparam logic [LABEL_W-1:0] EPS_LABEL = 9'h1FF;

    // Wide enough to compare any index or count against the table size.
    localparam int CMP_W = 18;

    // One entry of the edge table, source in the lowest bits.
    typedef struct packed {
        logic [STATE_W-1:0] dst;
        logic [LABEL_W-1:0] lab;
        logic [STATE_W-1:0] src;
    } t_edge;

endpackage

// ----- rtl/nfass_ram.sv -----
// ----------------------------------------------------------------------------
// nfass_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module nfass_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/nfa_state_set_engine_core.sv -----
// ----------------------------------------------------------------------------
// nfa_state_set_engine_core
// Thompson NFA simulation over a bitmap state set with an edge table in RAM.
// ----------------------------------------------------------------------------
// Usage: input items arrive on s_axis; tuser holds the operation, tdata the
// edge and set word fields. Each item yields one result item on m_axis with
// the addressed set word in tdata and the empty flag in tuser. The user must
// write the edge count register on the cfg channel only while the block is
// idle; the block itself does not enforce this. Edge writes, set word writes
// and reads pass through the response state to the output register. A move
// streams the valid edges through the edge RAM read port, one a cycle. A
// closure first scans all SET_WORDS*64 state bits, one a cycle, pushing set
// states onto the pending stack RAM, then pops each pending state and streams
// all valid edges for it.
// One item is processed at a time; s_axis_tready is high only while idle.
// The result sits in an output register, so a new item is taken while it
// waits; a finished item waits for that register when the receiver stalls.
// Reset clears the state set, the stack pointer and the edge count; the edge
// table and stack RAM are not cleared.
// ----------------------------------------------------------------------------
module nfa_state_set_engine_core
    import nfass_pkg::*;
#(
    parameter int SET_WORDS = 4,
    parameter int EDGES     = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Input items.
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // tdata from bit 0: edge_index[9:0], source_state[17:10], symbol[26:18],
    // target_state[34:27], word_index[36:35], word_value[100:37], zero pad.
    input  logic [IN_DATA_W-1:0] s_axis_tdata,
    // tuser: operation[2:0].
    input  logic [2:0]           s_axis_tuser,
    // Result items.
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // tdata: set_word[63:0].
    output logic [WORD_W-1:0]    m_axis_tdata,
    // tuser: set_empty[0].
    output logic [0:0]           m_axis_tuser,
    // Configuration: edge_count.
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int NUM_STATES = SET_WORDS * WORD_W;
    localparam int SB  = $clog2(NUM_STATES);
    localparam int EAW = $clog2(EDGES);
    localparam int CW  = $clog2(EDGES + 1);
    localparam int DW  = ((SB > STATE_W) ? SB : STATE_W) + 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PUSH = 3'd1;
    localparam logic [2:0] S_POP  = 3'd2;
    localparam logic [2:0] S_POPW = 3'd3;
    localparam logic [2:0] S_EPS  = 3'd4;
    localparam logic [2:0] S_MOVE = 3'd5;
    localparam logic [2:0] S_RESP = 3'd6;

    logic [2:0]            r_state, n_state;
    logic [NUM_STATES-1:0] r_set, n_set;
    logic [NUM_STATES-1:0] r_next, n_next;
    logic [SB:0]           r_sp, n_sp;
    logic [SB-1:0]         r_st, n_st;
    logic [SB-1:0]         r_u, n_u;
    logic [CW-1:0]         r_issue, n_issue;
    logic                  r_dv, n_dv;
    logic [CFG_W-1:0]      r_edge_count;
    logic [LABEL_W-1:0]    r_sym, n_sym;
    logic [WIDX_W-1:0]     r_widx, n_widx;
    logic                  r_ovalid, n_ovalid;
    logic [WORD_W-1:0]     r_oword, n_oword;
    logic                  r_oempty, n_oempty;

    // Input field views.
    logic [EIDX_W-1:0]  w_eidx;
    logic [STATE_W-1:0] w_src, w_dst;
    logic [LABEL_W-1:0] w_sym;
    logic [WIDX_W-1:0]  w_widx;
    logic [WORD_W-1:0]  w_wval;
    logic               w_in_acc;

    assign w_eidx   = s_axis_tdata[9:0];
    assign w_src    = s_axis_tdata[17:10];
    assign w_sym    = s_axis_tdata[26:18];
    assign w_dst    = s_axis_tdata[34:27];
    assign w_widx   = s_axis_tdata[36:35];
    assign w_wval   = s_axis_tdata[100:37];
    assign w_in_acc = s_axis_tvalid && s_axis_tready;

    // Effective edge count, clipped to the table size.
    logic [CMP_W-1:0] w_cnt_ext;
    logic [CW-1:0]    w_n;
    assign w_cnt_ext = CMP_W'(r_edge_count);
    assign w_n = (w_cnt_ext > CMP_W'(EDGES)) ? CW'(EDGES) : CW'(w_cnt_ext);

    // Edge table write address and range check.
    logic [EAW+EIDX_W-1:0] w_eidx_ext;
    logic                  w_eidx_ok;
    assign w_eidx_ext = {{EAW{1'b0}}, w_eidx};
    assign w_eidx_ok  = CMP_W'(w_eidx) < CMP_W'(EDGES);

    // Edge table RAM.
    t_edge          w_erd;
    logic           w_ewe;
    logic [EAW-1:0] w_eraddr;
    t_edge          w_ewdata;

    assign w_ewe    = w_in_acc && (s_axis_tuser == OP_WRITE_EDGE) && w_eidx_ok;
    assign w_ewdata = '{dst: w_dst, lab: w_sym, src: w_src};
    assign w_eraddr = r_issue[EAW-1:0];

    nfass_ram #(.WIDTH(EDGE_W), .DEPTH(EDGES)) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (w_ewe),
        .i_waddr (w_eidx_ext[EAW-1:0]),
        .i_wdata (w_ewdata),
        .i_raddr (w_eraddr),
        .o_rdata (w_erd)
    );

    // Pending stack RAM.
    logic          w_swe;
    logic [SB-1:0] w_swdata;
    logic [SB-1:0] w_srd;
    logic [SB:0]   w_sp_dec;
    assign w_sp_dec = r_sp - 1'b1;

    nfass_ram #(.WIDTH(SB), .DEPTH(NUM_STATES)) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (w_swe),
        .i_waddr (r_sp[SB-1:0]),
        .i_wdata (w_swdata),
        .i_raddr (w_sp_dec[SB-1:0]),
        .o_rdata (w_srd)
    );

    // Fields of the edge that is in the compare stage.
    logic [DW-1:0] w_edst, w_esrc;
    logic          w_dst_ok, w_src_ok;
    assign w_edst   = DW'(w_erd.dst);
    assign w_esrc   = DW'(w_erd.src);
    assign w_dst_ok = w_edst < DW'(NUM_STATES);
    assign w_src_ok = w_esrc < DW'(NUM_STATES);

    // Addressed word of the current set.
    logic [WORD_W-1:0] w_word;
    always_comb begin
        w_word = '0;
        for (int w = 0; w < SET_WORDS; w++) begin
            if (32'(r_widx) == w) begin
                w_word = r_set[w*WORD_W +: WORD_W];
            end
        end
    end

    // Sequencer.
    always_comb begin
        n_state  = r_state;
        n_set    = r_set;
        n_next   = r_next;
        n_sp     = r_sp;
        n_st     = r_st;
        n_u      = r_u;
        n_issue  = r_issue;
        n_dv     = 1'b0;
        n_sym    = r_sym;
        n_widx   = r_widx;
        n_ovalid = r_ovalid;
        n_oword  = r_oword;
        n_oempty = r_oempty;
        w_swe    = 1'b0;
        w_swdata = r_st;

        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_sym   = w_sym;
                    n_widx  = w_widx;
                    n_issue = '0;
                    n_st    = '0;
                    n_next  = '0;
                    case (s_axis_tuser)
                        OP_WRITE_WORD: begin
                            for (int w = 0; w < SET_WORDS; w++) begin
                                if (32'(w_widx) == w) begin
                                    n_set[w*WORD_W +: WORD_W] = w_wval;
                                end
                            end
                            n_state = S_RESP;
                        end
                        OP_CLOSURE: begin
                            n_sp    = '0;
                            n_state = S_PUSH;
                        end
                        OP_MOVE: n_state = S_MOVE;
                        default: n_state = S_RESP;
                    endcase
                end
            end
            // Push every state of the set onto the pending stack.
            S_PUSH: begin
                if (r_set[r_st]) begin
                    w_swe    = 1'b1;
                    w_swdata = r_st;
                    n_sp     = r_sp + 1'b1;
                end
                n_st = r_st + 1'b1;
                if (r_st == SB'(NUM_STATES - 1)) begin
                    n_state = S_POP;
                end
            end
            // Pop one pending state, or finish when the stack is empty.
            S_POP: begin
                if (r_sp == '0) begin
                    n_state = S_RESP;
                end else begin
                    n_sp    = w_sp_dec;
                    n_state = S_POPW;
                end
            end
            S_POPW: begin
                n_u     = w_srd;
                n_issue = '0;
                n_state = S_EPS;
            end
            // Stream the edges; add and push unseen epsilon targets of r_u.
            S_EPS: begin
                if (r_issue < w_n) begin
                    n_issue = r_issue + 1'b1;
                    n_dv    = 1'b1;
                end
                if (r_dv && (w_esrc == DW'(r_u)) && (w_erd.lab == EPS_LABEL)
                        && w_dst_ok && !r_set[w_edst[SB-1:0]]) begin
                    n_set[w_edst[SB-1:0]] = 1'b1;
                    if (r_sp < (SB+1)'(NUM_STATES)) begin
                        w_swe    = 1'b1;
                        w_swdata = w_edst[SB-1:0];
                        n_sp     = r_sp + 1'b1;
                    end
                end
                if ((r_issue == w_n) && !r_dv) begin
                    n_state = S_POP;
                end
            end
            // Stream the edges and collect targets reached on the symbol.
            S_MOVE: begin
                if (r_issue < w_n) begin
                    n_issue = r_issue + 1'b1;
                    n_dv    = 1'b1;
                end
                if (r_dv && (w_erd.lab == r_sym) && w_src_ok && w_dst_ok
                        && r_set[w_esrc[SB-1:0]]) begin
                    n_next[w_edst[SB-1:0]] = 1'b1;
                end
                if ((r_issue == w_n) && !r_dv) begin
                    n_set   = r_next;
                    n_state = S_RESP;
                end
            end
            // Hand the result to the output register once it is free.
            S_RESP: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_oword  = w_word;
                    n_oempty = (r_set == '0);
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_set        <= '0;
            r_sp         <= '0;
            r_dv         <= 1'b0;
            r_ovalid     <= 1'b0;
            r_edge_count <= '0;
        end else begin
            r_state  <= n_state;
            r_set    <= n_set;
            r_sp     <= n_sp;
            r_dv     <= n_dv;
            r_ovalid <= n_ovalid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_edge_count <= i_cfg_data;
            end
        end
    end

    // Payload and working registers.
    always_ff @(posedge i_clk) begin
        r_next   <= n_next;
        r_st     <= n_st;
        r_u      <= n_u;
        r_issue  <= n_issue;
        r_sym    <= n_sym;
        r_widx   <= n_widx;
        r_oword  <= n_oword;
        r_oempty <= n_oempty;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_oword;
    assign m_axis_tuser  = r_oempty;

    // The stack pointer never passes the stack depth.
    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= (SB+1)'(NUM_STATES))
        else $error("pending stack pointer out of range");

    // The current set does not change while a move is still scanning.
    a_move_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOVE) && (n_state == S_MOVE) |=> $stable(r_set))
        else $error("set changed during move scan");

    // An accepted item always leaves the idle state.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state != S_IDLE))
        else $error("accepted item did not start");

    // Edge read data is only consumed in a scan state.
    a_dv_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv |-> ((r_state == S_EPS) || (r_state == S_MOVE)))
        else $error("edge data valid outside a scan");

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the NFA state set engine core.
// Drives edge writes, set word writes, closures, moves and reads under random
// input bursts and output stalls, and checks every result item against a
// model of the edge table and state set kept in the bench.
// ----------------------------------------------------------------------------
module tb
    import nfass_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NWORDS   = 4;
    localparam int NEDGES   = 1024;
    localparam int NSTATES  = NWORDS * 64;
    localparam int WDOG_MAX = 400000;

    // Bench-side model of the state set and edge table.
    class nfa_scoreboard;
        logic [WORD_W-1:0] state_set [NWORDS];
        t_edge             edge_mem [NEDGES];
        int unsigned       live_edges;
        logic [64:0]       pending_q [$];
        int                errors;

        function new();
            for (int w = 0; w < NWORDS; w++) state_set[w] = '0;
            live_edges = 0;
            errors = 0;
        endfunction

        function void set_edge_count(logic [CFG_W-1:0] v);
            live_edges = (v > NEDGES) ? NEDGES : v;
        endfunction

        function bit has_state(int unsigned st);
            if (st >= NSTATES) return 1'b1;
            return state_set[st / 64][st % 64];
        endfunction

        // Epsilon closure with an explicit stack of pending states.
        function void close_set();
            int unsigned stk [$];
            int unsigned u;
            t_edge e;
            for (int st = 0; st < NSTATES; st++)
                if (has_state(st)) stk.push_back(st);
            while (stk.size() > 0) begin
                u = stk.pop_back();
                for (int i = 0; i < live_edges; i++) begin
                    e = edge_mem[i];
                    if (e.src == u && e.lab == EPS_LABEL && !has_state(e.dst)) begin
                        state_set[e.dst / 64][e.dst % 64] = 1'b1;
                        stk.push_back(e.dst);
                    end
                end
            end
        endfunction

        function void move_set(logic [LABEL_W-1:0] sym);
            logic [WORD_W-1:0] nxt [NWORDS];
            t_edge e;
            for (int w = 0; w < NWORDS; w++) nxt[w] = '0;
            for (int i = 0; i < live_edges; i++) begin
                e = edge_mem[i];
                if (e.lab == sym && has_state(e.src)) nxt[e.dst / 64][e.dst % 64] = 1'b1;
            end
            for (int w = 0; w < NWORDS; w++) state_set[w] = nxt[w];
        endfunction

        // Applies one accepted input item and queues its expected result.
        function void note_input(logic [2:0] op, logic [IN_DATA_W-1:0] d);
            logic [WORD_W-1:0] any;
            logic [WIDX_W-1:0] widx;
            t_edge e;
            widx = d[36:35];
            e.src = d[17:10];
            e.lab = d[26:18];
            e.dst = d[34:27];
            case (op)
                OP_WRITE_EDGE: edge_mem[d[9:0]] = e;
                OP_WRITE_WORD: state_set[widx] = d[100:37];
                OP_CLOSURE:    close_set();
                OP_MOVE:       move_set(e.lab);
                default: ;
            endcase
            any = '0;
            for (int w = 0; w < NWORDS; w++) any |= state_set[w];
            pending_q.push_back({(any == '0), state_set[widx]});
        endfunction

        function void check_result(logic [WORD_W-1:0] word, logic empty);
            logic [64:0] exp;
            if (pending_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result item: word %h empty %b",
                                           word, empty);
                return;
            end
            exp = pending_q.pop_front();
            if (exp[63:0] !== word || exp[64] !== empty) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected word %h empty %b, got word %h empty %b",
                             exp[63:0], exp[64], word, empty);
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata;
    logic [2:0]           s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [WORD_W-1:0]    m_axis_tdata;
    logic [0:0]           m_axis_tuser;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_W-1:0]     i_cfg_data;

    nfa_scoreboard sb;
    int            idle_cycles;
    int            n_sent;
    int            n_closure;
    int            n_move;
    bit            stall_on;

    nfa_state_set_engine_core #(.SET_WORDS(NWORDS), .EDGES(NEDGES)) u_dut (.*);

    // Clock generation.
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Result sampling and watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser[0]);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WDOG_MAX) begin
                $display("watchdog expired");
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Receiver stall pattern: alternates free-running and stalling stretches.
    initial begin
        m_axis_tready = 1'b0;
        stall_on = 1'b0;
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 63) == 0) stall_on = !stall_on;
            m_axis_tready <= stall_on ? ($urandom_range(0, 3) == 0) : 1'b1;
        end
    end

    task automatic send_item(logic [2:0] op, logic [IN_DATA_W-1:0] d);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= d;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_input(op, d);
        n_sent++;
        if (op == OP_CLOSURE) n_closure++;
        if (op == OP_MOVE) n_move++;
        @(negedge i_clk);
    endtask

    function automatic logic [IN_DATA_W-1:0] pack_item(logic [9:0] eidx, logic [7:0] src,
                                                       logic [8:0] sym, logic [7:0] dst,
                                                       logic [1:0] widx, logic [63:0] wv);
        return {3'b000, wv, widx, dst, sym, src, eidx};
    endfunction

    // Sender gaps between items when idling is allowed.
    task automatic gap();
        int g;
        g = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_count(logic [CFG_W-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_edge_count(v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Writes edges 0..n-1 with labels drawn from a small alphabet plus epsilon.
    task automatic load_graph(int n, int span);
        logic [8:0] lab;
        for (int i = 0; i < n; i++) begin
            lab = ($urandom_range(0, 2) == 0) ? EPS_LABEL : 9'($urandom_range(0, 3));
            send_item(OP_WRITE_EDGE, pack_item(10'(i), 8'($urandom_range(0, span)), lab,
                                               8'($urandom_range(0, span)), 2'($urandom),
                                               {$urandom, $urandom}));
            gap();
        end
    endtask

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            2: return 64'(1) << $urandom_range(0, 63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Random traffic over a loaded graph; mostly set writes, closures and moves.
    task automatic random_phase(int items, int n_edges, int span);
        int k;
        logic [2:0] op;
        for (int i = 0; i < items; i++) begin
            k = $urandom_range(0, 99);
            if (k < 25) op = OP_WRITE_WORD;
            else if (k < 50) op = OP_CLOSURE;
            else if (k < 75) op = OP_MOVE;
            else if (k < 85) op = OP_READ;
            else if (k < 92) op = 3'($urandom_range(5, 7));
            else op = OP_WRITE_EDGE;
            send_item(op, pack_item(10'($urandom_range(0, n_edges > 0 ? n_edges - 1 : 0)),
                                    8'($urandom_range(0, span)),
                                    ($urandom_range(0, 3) == 0) ? EPS_LABEL
                                        : 9'($urandom_range(0, 4)),
                                    8'($urandom_range(0, span)), 2'($urandom),
                                    rand_word()));
            gap();
        end
    endtask

    initial begin
        sb = new();
        idle_cycles = 0;
        n_sent = 0;
        n_closure = 0;
        n_move = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = OP_READ;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty set, every operation with no edges, field extremes.
        send_item(OP_READ, pack_item('0, '0, '0, '0, 2'd0, '0));
        send_item(OP_CLOSURE, pack_item('0, '0, '0, '0, 2'd3, '0));
        send_item(OP_WRITE_WORD, pack_item('1, '1, '1, '1, 2'd3, '1));
        send_item(OP_WRITE_WORD, pack_item('0, '0, '0, '0, 2'd0, 64'h1));
        send_item(OP_MOVE, pack_item('0, '0, 9'd0, '0, 2'd0, '0));
        send_item(3'd5, pack_item('1, '1, '1, '1, 2'd3, '1));
        send_item(3'd7, pack_item('0, '0, '0, '0, 2'd1, '0));
        // Small chain: 0 -eps-> 1 -eps-> 255, 1 -'a'-> 200, 255 -0xFF-> 0.
        send_item(OP_WRITE_EDGE, pack_item(10'd0, 8'd0, EPS_LABEL, 8'd1, 2'd0, '0));
        send_item(OP_WRITE_EDGE, pack_item(10'd1, 8'd1, EPS_LABEL, 8'd255, 2'd0, '0));
        send_item(OP_WRITE_EDGE, pack_item(10'd2, 8'd1, 9'd97, 8'd200, 2'd0, '0));
        send_item(OP_WRITE_EDGE, pack_item(10'd3, 8'd255, 9'd255, 8'd0, 2'd0, '0));
        send_item(OP_WRITE_EDGE, pack_item(10'd1023, 8'd9, 9'd1, 8'd9, 2'd0, '1));
        drain();
        write_count(11'd4);
        send_item(OP_WRITE_WORD, pack_item('0, '0, '0, '0, 2'd0, 64'h1));
        send_item(OP_CLOSURE, pack_item('0, '0, '0, '0, 2'd3, '0));
        send_item(OP_READ, pack_item('0, '0, '0, '0, 2'd0, '0));
        send_item(OP_MOVE, pack_item('0, '0, 9'd97, '0, 2'd3, '0));
        send_item(OP_WRITE_WORD, pack_item('0, '0, '0, '0, 2'd3, 64'h8000_0000_0000_0000));
        send_item(OP_MOVE, pack_item('0, '0, 9'd255, '0, 2'd0, '0));
        send_item(OP_MOVE, pack_item('0, '0, EPS_LABEL, '0, 2'd0, '0));
        send_item(OP_MOVE, pack_item('0, '0, 9'd3, '0, 2'd0, '0));
        drain();

        // Random phases over graphs of varying size and edge count settings.
        load_graph(24, 15);
        drain();
        write_count(11'd24);
        random_phase(120, 24, 15);
        drain();
        load_graph(40, 255);
        drain();
        write_count(11'd40);
        random_phase(120, 40, 255);
        drain();
        write_count(11'd0);
        random_phase(30, 1, 255);
        drain();
        write_count(11'd12);
        random_phase(60, 12, 63);
        drain();

        $display("sent %0d items (%0d closures, %0d moves) over edge counts 0 to 40",
                 n_sent, n_closure, n_move);
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.errors, sb.pending_q.size());
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
rtl/nfass_pkg.sv
rtl/nfass_ram.sv
rtl/nfa_state_set_engine_core.sv
tb/tb.sv
